// File: sv/lcd4_pkg.sv
package lcd4_pkg;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
  } in_t;

  typedef struct packed {
    logic [3:0] lcd_nibble;
    logic       lcd_enable;
    logic       lcd_register_select;
    logic       lcd_read_write;
    logic       busy_res;
    logic       dropped;
  } out_t;

  typedef struct packed {
    logic [15:0] data_setup_us;
    logic [15:0] enable_pulse_us;
    logic [15:0] power_wait_us;
    logic [15:0] reset_gap_us;
    logic [15:0] command_gap_us;
    logic [15:0] clear_wait_us;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETUP  = 2'd1,
    PH_ENABLE = 2'd2,
    PH_GAP    = 2'd3
  } phase_t;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_INIT  = 2'd1;
  localparam logic [1:0] MODE_INSTR = 2'd2;
  localparam logic [1:0] MODE_DATA  = 2'd3;

  localparam logic [2:0] REG_DATA_SETUP   = 3'd0;
  localparam logic [2:0] REG_ENABLE_PULSE = 3'd1;
  localparam logic [2:0] REG_POWER_WAIT   = 3'd2;
  localparam logic [2:0] REG_RESET_GAP    = 3'd3;
  localparam logic [2:0] REG_COMMAND_GAP  = 3'd4;
  localparam logic [2:0] REG_CLEAR_WAIT   = 3'd5;

  localparam logic [4:0] STEP_NONE      = 5'd0;
  localparam logic [4:0] STEP_POWER     = 5'd1;
  localparam logic [4:0] STEP_RESET_END = 5'd4;
  localparam logic [4:0] STEP_LAST      = 5'd13;

  localparam logic [15:0] DATA_SETUP_RST   = 16'd20;
  localparam logic [15:0] ENABLE_PULSE_RST = 16'd20;
  localparam logic [15:0] POWER_WAIT_RST   = 16'd15000;
  localparam logic [15:0] RESET_GAP_RST    = 16'd5000;
  localparam logic [15:0] COMMAND_GAP_RST  = 16'd100;
  localparam logic [15:0] CLEAR_WAIT_RST   = 16'd2000;

  // Ticks left after the first one; a zero length still lasts one tick.
  function automatic logic [15:0] phase_count(input logic [15:0] len);
    phase_count = (len == 16'd0) ? 16'd0 : len - 16'd1;
  endfunction

  // Init nibble sent at a given init step: reset nibbles, 4-bit select,
  // then function set, display on, entry mode and clear as nibble pairs.
  function automatic logic [3:0] init_nibble(input logic [4:0] step);
    unique case (step)
      5'd2:    init_nibble = 4'h3;
      5'd3:    init_nibble = 4'h3;
      5'd4:    init_nibble = 4'h3;
      5'd5:    init_nibble = 4'h2;
      5'd6:    init_nibble = 4'h2;
      5'd7:    init_nibble = 4'h8;
      5'd8:    init_nibble = 4'h0;
      5'd9:    init_nibble = 4'hC;
      5'd10:   init_nibble = 4'h0;
      5'd11:   init_nibble = 4'h6;
      5'd12:   init_nibble = 4'h0;
      5'd13:   init_nibble = 4'h1;
      default: init_nibble = 4'h0;
    endcase
  endfunction

endpackage

// File: sv/lcd4_core.sv
module lcd4_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step_en,
  input  lcd4_pkg::in_t   item,
  input  lcd4_pkg::cfg_t  cfg,
  output lcd4_pkg::out_t  result
);

  logic [15:0]      count, count_next;
  logic [4:0]       init_step, init_step_next;
  lcd4_pkg::phase_t phase, phase_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             low_pending, low_pending_next;
  logic [3:0]       data_lines, data_lines_next;
  logic             enable_line, enable_line_next;
  logic             select_line, select_line_next;
  logic             busy, drop;
  logic [15:0]      gap_len;
  logic [4:0]       step_inc;

  assign busy     = (init_step != lcd4_pkg::STEP_NONE) || (phase != lcd4_pkg::PH_IDLE);
  assign step_inc = init_step + 5'd1;

  always_comb begin
    priority if (init_step <= lcd4_pkg::STEP_RESET_END) begin
      gap_len = cfg.reset_gap_us;
    end else if (init_step < lcd4_pkg::STEP_LAST) begin
      gap_len = cfg.command_gap_us;
    end else begin
      gap_len = cfg.clear_wait_us;
    end
  end

  always_comb begin
    count_next       = count;
    init_step_next   = init_step;
    phase_next       = phase;
    held_byte_next   = held_byte;
    low_pending_next = low_pending;
    data_lines_next  = data_lines;
    enable_line_next = enable_line;
    select_line_next = select_line;
    drop             = 1'b0;
    if (busy) begin
      drop = (item.mode != lcd4_pkg::MODE_TICK);
      if (count != 16'd0) begin
        count_next = count - 16'd1;
      end else begin
        unique case (phase)
          lcd4_pkg::PH_SETUP: begin
            enable_line_next = 1'b1;
            phase_next       = lcd4_pkg::PH_ENABLE;
            count_next       = lcd4_pkg::phase_count(cfg.enable_pulse_us);
          end
          lcd4_pkg::PH_ENABLE: begin
            enable_line_next = 1'b0;
            if (init_step != lcd4_pkg::STEP_NONE) begin
              phase_next = lcd4_pkg::PH_GAP;
              count_next = lcd4_pkg::phase_count(gap_len);
            end else if (low_pending) begin
              low_pending_next = 1'b0;
              data_lines_next  = held_byte[3:0];
              phase_next       = lcd4_pkg::PH_SETUP;
              count_next       = lcd4_pkg::phase_count(cfg.data_setup_us);
            end else begin
              phase_next = lcd4_pkg::PH_IDLE;
              count_next = 16'd0;
            end
          end
          lcd4_pkg::PH_GAP: begin
            if (init_step >= lcd4_pkg::STEP_POWER && init_step < lcd4_pkg::STEP_LAST) begin
              init_step_next   = step_inc;
              data_lines_next  = lcd4_pkg::init_nibble(step_inc);
              enable_line_next = 1'b0;
              phase_next       = lcd4_pkg::PH_SETUP;
              count_next       = lcd4_pkg::phase_count(cfg.data_setup_us);
            end else begin
              init_step_next = lcd4_pkg::STEP_NONE;
              phase_next     = lcd4_pkg::PH_IDLE;
              count_next     = 16'd0;
            end
          end
          lcd4_pkg::PH_IDLE: begin
            init_step_next = lcd4_pkg::STEP_NONE;
            count_next     = 16'd0;
          end
          default: begin
            phase_next = lcd4_pkg::PH_IDLE;
          end
        endcase
      end
    end else if (item.mode == lcd4_pkg::MODE_INIT) begin
      data_lines_next  = 4'h0;
      enable_line_next = 1'b0;
      select_line_next = 1'b0;
      low_pending_next = 1'b0;
      init_step_next   = lcd4_pkg::STEP_POWER;
      phase_next       = lcd4_pkg::PH_GAP;
      count_next       = lcd4_pkg::phase_count(cfg.power_wait_us);
    end else if (item.mode != lcd4_pkg::MODE_TICK) begin
      select_line_next = (item.mode == lcd4_pkg::MODE_DATA);
      held_byte_next   = item.byte_value;
      low_pending_next = 1'b1;
      data_lines_next  = item.byte_value[7:4];
      enable_line_next = 1'b0;
      phase_next       = lcd4_pkg::PH_SETUP;
      count_next       = lcd4_pkg::phase_count(cfg.data_setup_us);
    end
  end

  always_comb begin
    result.lcd_nibble          = data_lines_next;
    result.lcd_enable          = enable_line_next;
    result.lcd_register_select = select_line_next;
    result.lcd_read_write      = 1'b0;
    result.busy_res            = (init_step_next != lcd4_pkg::STEP_NONE) ||
                                 (phase_next != lcd4_pkg::PH_IDLE);
    result.dropped             = drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= 16'd0;
      init_step   <= lcd4_pkg::STEP_NONE;
      phase       <= lcd4_pkg::PH_IDLE;
      held_byte   <= 8'h00;
      low_pending <= 1'b0;
      data_lines  <= 4'h0;
      enable_line <= 1'b0;
      select_line <= 1'b0;
    end else if (step_en) begin
      count       <= count_next;
      init_step   <= init_step_next;
      phase       <= phase_next;
      held_byte   <= held_byte_next;
      low_pending <= low_pending_next;
      data_lines  <= data_lines_next;
      enable_line <= enable_line_next;
      select_line <= select_line_next;
    end
  end

  a_enable_in_pulse: assert property (@(posedge clk) disable iff (rst)
    enable_line |-> (phase == lcd4_pkg::PH_ENABLE))
    else $error("enable high outside the enable phase");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    init_step <= lcd4_pkg::STEP_LAST)
    else $error("init step past the last nibble");

  a_low_not_in_init: assert property (@(posedge clk) disable iff (rst)
    low_pending |-> (init_step == lcd4_pkg::STEP_NONE))
    else $error("low nibble pending during init");

endmodule

// File: sv/lcd4_obuf.sv
module lcd4_obuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcd4_pkg::out_t push_data,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output lcd4_pkg::out_t out_data
);

  logic           skid_valid;
  lcd4_pkg::out_t skid_data;
  logic           head_free;

  assign space     = !skid_valid;
  assign head_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (head_free) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while head is empty");

endmodule

// File: sv/char_lcd_4bit_write_sequencer_top.sv
// Channel | Direction | Handshake              | Beat
// --------+-----------+------------------------+------------------------------------
// in      | input     | in_valid / in_ready    | in_data: mode, byte_value (1 tick)
// out     | output    | out_valid / out_ready  | out_data: LCD line levels, busy, drop
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index (register), cfg_data (16b)
//
// Each in beat is one microsecond tick; the sequencer state advances in the
// cycle the beat is taken, and the line levels of that tick are registered
// in the output buffer. Throughput is one beat per cycle while in_ready is high.
// Synchronous reset restores the timing registers to their defaults and
// puts the sequencer idle with all lines low.
// A stalled out channel parks one beat in a skid stage; in_ready drops only
// once that stage is full. cfg_ready is always high.
module char_lcd_4bit_write_sequencer_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lcd4_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lcd4_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  lcd4_pkg::cfg_t cfg;
  lcd4_pkg::out_t result;
  logic           in_fire;
  logic           space;

  assign cfg_ready = 1'b1;
  assign in_ready  = space;
  assign in_fire   = in_valid && in_ready;

  // Timing registers; writes to an index past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_setup_us   <= lcd4_pkg::DATA_SETUP_RST;
      cfg.enable_pulse_us <= lcd4_pkg::ENABLE_PULSE_RST;
      cfg.power_wait_us   <= lcd4_pkg::POWER_WAIT_RST;
      cfg.reset_gap_us    <= lcd4_pkg::RESET_GAP_RST;
      cfg.command_gap_us  <= lcd4_pkg::COMMAND_GAP_RST;
      cfg.clear_wait_us   <= lcd4_pkg::CLEAR_WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lcd4_pkg::REG_DATA_SETUP:   cfg.data_setup_us   <= cfg_data;
        lcd4_pkg::REG_ENABLE_PULSE: cfg.enable_pulse_us <= cfg_data;
        lcd4_pkg::REG_POWER_WAIT:   cfg.power_wait_us   <= cfg_data;
        lcd4_pkg::REG_RESET_GAP:    cfg.reset_gap_us    <= cfg_data;
        lcd4_pkg::REG_COMMAND_GAP:  cfg.command_gap_us  <= cfg_data;
        lcd4_pkg::REG_CLEAR_WAIT:   cfg.clear_wait_us   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the sequencer once per accepted tick.
  lcd4_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (in_fire),
    .item    (in_data),
    .cfg     (cfg),
    .result  (result)
  );

  // Hold results until taken; skid one beat under backpressure.
  lcd4_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: test/char_lcd_4bit_write_sequencer_top_tb.sv
`timescale 1ns / 100ps

module char_lcd_4bit_write_sequencer_top_tb;

  localparam int GAP_MAX    = 17;
  localparam int TIMEOUT_NS = 36_000_000;  // several times the slowest run
  localparam int PLAN_LEN   = 21;
  localparam int ZERO_ROW   = 7;           // rows from here on run with every length at zero

  // Power-up nibbles, step 2 in the top nibble down to step 13 in the bottom one.
  localparam logic [47:0] INIT_SEQ = 48'h333228_0C0601;

  localparam lcd4_pkg::cfg_t CFG_DEFAULT = {lcd4_pkg::DATA_SETUP_RST,
                                            lcd4_pkg::ENABLE_PULSE_RST,
                                            lcd4_pkg::POWER_WAIT_RST,
                                            lcd4_pkg::RESET_GAP_RST,
                                            lcd4_pkg::COMMAND_GAP_RST,
                                            lcd4_pkg::CLEAR_WAIT_RST};

  // One directed beat; when pinned, want is the result to expect instead of the
  // predicted one.
  typedef struct packed {
    lcd4_pkg::in_t  item;
    logic           pinned;
    lcd4_pkg::out_t want;
  } row_t;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  lcd4_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b1;
  lcd4_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [2:0]     cfg_index = '0;
  logic [15:0]    cfg_data  = '0;

  char_lcd_4bit_write_sequencer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Line predictor: timing registers and sequencer state as the block should
  // hold them. Only the stimulus process touches these, right after the edge
  // that takes a beat, so the next decision always sees the updated state.
  // ---------------------------------------------------------------------------
  lcd4_pkg::cfg_t   lcd_cfg      = CFG_DEFAULT;
  logic [15:0]      us_left      = '0;   // ticks left in the current phase after this one
  logic [4:0]       init_at      = lcd4_pkg::STEP_NONE;
  lcd4_pkg::phase_t strobe_phase = lcd4_pkg::PH_IDLE;
  logic [7:0]       byte_held    = '0;
  logic             low_due      = 1'b0;
  logic [3:0]       d_lines      = '0;
  logic             e_line       = 1'b0;
  logic             rs_line      = 1'b0;

  lcd4_pkg::out_t   lcd_expected [$];    // line levels still owed by the block
  int               n_in   = 0;          // beats taken on the in channel
  int               n_out  = 0;          // result beats matched against an expectation
  int               errors = 0;
  logic             quiet  = 1'b0;       // no idling on either side while set
  int               stall_left = 0;

  function automatic logic lcd_busy();
    return (init_at != lcd4_pkg::STEP_NONE) || (strobe_phase != lcd4_pkg::PH_IDLE);
  endfunction

  // The tick on which a phase is entered is already its first microsecond;
  // a zero length still lasts one tick.
  task automatic begin_phase(input lcd4_pkg::phase_t p, input logic [15:0] len);
    strobe_phase = p;
    us_left      = (len == 16'd0) ? 16'd0 : len - 16'd1;
  endtask

  task automatic put_nibble(input logic [3:0] nib);
    d_lines = nib;
    e_line  = 1'b0;
    begin_phase(lcd4_pkg::PH_SETUP, lcd_cfg.data_setup_us);
  endtask

  // Advance one microsecond tick and return the line levels after it.
  task automatic lcd_tick(input lcd4_pkg::in_t it, output lcd4_pkg::out_t r);
    logic drop;
    drop = 1'b0;
    if (lcd_busy()) begin
      // A request while busy is dropped, but time still moves on.
      drop = (it.mode != lcd4_pkg::MODE_TICK);
      if (us_left != 16'd0) begin
        us_left = us_left - 16'd1;
      end else begin
        case (strobe_phase)
          lcd4_pkg::PH_SETUP: begin
            e_line = 1'b1;
            begin_phase(lcd4_pkg::PH_ENABLE, lcd_cfg.enable_pulse_us);
          end
          lcd4_pkg::PH_ENABLE: begin
            e_line = 1'b0;
            if (init_at != lcd4_pkg::STEP_NONE) begin
              begin_phase(lcd4_pkg::PH_GAP,
                          (init_at <= lcd4_pkg::STEP_RESET_END) ? lcd_cfg.reset_gap_us :
                          (init_at < lcd4_pkg::STEP_LAST) ? lcd_cfg.command_gap_us :
                          lcd_cfg.clear_wait_us);
            end else if (low_due) begin
              low_due = 1'b0;
              put_nibble(byte_held[3:0]);
            end else begin
              strobe_phase = lcd4_pkg::PH_IDLE;
              us_left      = '0;
            end
          end
          lcd4_pkg::PH_GAP: begin
            if (init_at >= lcd4_pkg::STEP_POWER && init_at < lcd4_pkg::STEP_LAST) begin
              init_at = init_at + 5'd1;
              put_nibble(INIT_SEQ[4 * (lcd4_pkg::STEP_LAST - init_at) +: 4]);
            end else begin
              init_at      = lcd4_pkg::STEP_NONE;
              strobe_phase = lcd4_pkg::PH_IDLE;
              us_left      = '0;
            end
          end
          default: begin
            init_at = lcd4_pkg::STEP_NONE;
            us_left = '0;
          end
        endcase
      end
    end else if (it.mode == lcd4_pkg::MODE_INIT) begin
      // Power-up drives every line low before the first wait.
      d_lines = '0;
      e_line  = 1'b0;
      rs_line = 1'b0;
      low_due = 1'b0;
      init_at = lcd4_pkg::STEP_POWER;
      begin_phase(lcd4_pkg::PH_GAP, lcd_cfg.power_wait_us);
    end else if (it.mode != lcd4_pkg::MODE_TICK) begin
      rs_line   = (it.mode == lcd4_pkg::MODE_DATA);
      byte_held = it.byte_value;
      low_due   = 1'b1;
      put_nibble(it.byte_value[7:4]);
    end
    r.lcd_nibble          = d_lines;
    r.lcd_enable          = e_line;
    r.lcd_register_select = rs_line;
    r.lcd_read_write      = 1'b0;
    r.busy_res            = lcd_busy();
    r.dropped             = drop;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------

  // Offer one beat after a random gap and hold it until taken. Valid is left
  // high afterwards so a back-to-back beat does not drop it for a cycle.
  task automatic send_beat(input lcd4_pkg::in_t it, input logic pinned,
                           input lcd4_pkg::out_t want);
    lcd4_pkg::out_t r;
    int             gap;
    gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    lcd_tick(it, r);
    lcd_expected.push_back(pinned ? want : r);
    n_in++;
  endtask

  // Drop valid and hold until every owed beat has come back. Always waits for
  // a clock edge so the caller may raise valid again right after.
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_out != n_in);
  endtask

  // Tick until the sequencer goes idle, then drain the results.
  task automatic settle();
    lcd4_pkg::in_t t;
    while (lcd_busy()) begin
      t.mode       = lcd4_pkg::MODE_TICK;
      t.byte_value = 8'($urandom_range(0, 255));
      send_beat(t, 1'b0, '0);
    end
    wait_results();
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Load all six timing registers back to back; only called while idle.
  task automatic set_regs(input lcd4_pkg::cfg_t c);
    write_reg(lcd4_pkg::REG_DATA_SETUP,   c.data_setup_us);
    write_reg(lcd4_pkg::REG_ENABLE_PULSE, c.enable_pulse_us);
    write_reg(lcd4_pkg::REG_POWER_WAIT,   c.power_wait_us);
    write_reg(lcd4_pkg::REG_RESET_GAP,    c.reset_gap_us);
    write_reg(lcd4_pkg::REG_COMMAND_GAP,  c.command_gap_us);
    write_reg(lcd4_pkg::REG_CLEAR_WAIT,   c.clear_wait_us);
    cfg_valid <= 1'b0;
    lcd_cfg = c;
  endtask

  function automatic lcd4_pkg::cfg_t short_timing(input int top);
    lcd4_pkg::cfg_t c;
    c.data_setup_us   = 16'($urandom_range(0, top));
    c.enable_pulse_us = 16'($urandom_range(0, top));
    c.power_wait_us   = 16'($urandom_range(0, top));
    c.reset_gap_us    = 16'($urandom_range(0, top));
    c.command_gap_us  = 16'($urandom_range(0, top));
    c.clear_wait_us   = 16'($urandom_range(0, top));
    return c;
  endfunction

  // Mostly well-formed traffic: a request while idle, ticks while it runs,
  // and now and then a request that lands on a busy sequencer.
  task automatic run_random(input int count, input logic allow_init);
    lcd4_pkg::in_t it;
    int            k;
    for (k = 0; k < count; k++) begin
      if (k % 64 == 0) quiet <= ($urandom_range(0, 3) == 0);
      it.byte_value = 8'($urandom_range(0, 255));
      if (lcd_busy())
        it.mode = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) :
                                               lcd4_pkg::MODE_TICK;
      else if ($urandom_range(0, 2) == 0)
        it.mode = allow_init ? 2'($urandom_range(1, 3)) : 2'($urandom_range(2, 3));
      else
        it.mode = lcd4_pkg::MODE_TICK;
      // Pause now and then until the block has caught up.
      if ($urandom_range(0, 199) == 0) wait_results();
      send_beat(it, 1'b0, '0);
    end
  endtask

  // Directed beats. Pinned fields: nibble, then {enable, select, rw, busy, dropped}.
  row_t plan [PLAN_LEN] = '{
    // reset timing: quiet lines, then a write that is still in data setup
    {lcd4_pkg::MODE_TICK,  8'h00, 1'b1, 4'h0, 5'b00000},
    {lcd4_pkg::MODE_TICK,  8'hFF, 1'b1, 4'h0, 5'b00000},
    {lcd4_pkg::MODE_INSTR, 8'hFF, 1'b1, 4'hF, 5'b00010},
    {lcd4_pkg::MODE_DATA,  8'h00, 1'b1, 4'hF, 5'b00011},  // busy: dropped, select untouched
    {lcd4_pkg::MODE_INIT,  8'h81, 1'b1, 4'hF, 5'b00011},
    {lcd4_pkg::MODE_INSTR, 8'h7E, 1'b1, 4'hF, 5'b00011},
    {lcd4_pkg::MODE_TICK,  8'h3C, 1'b0, 4'h0, 5'b00000},
    // every length zero: each phase lasts a single tick
    {lcd4_pkg::MODE_DATA,  8'hA5, 1'b1, 4'hA, 5'b01010},
    {lcd4_pkg::MODE_TICK,  8'h00, 1'b0, 4'h0, 5'b00000},
    {lcd4_pkg::MODE_TICK,  8'h00, 1'b0, 4'h0, 5'b00000},
    {lcd4_pkg::MODE_TICK,  8'h00, 1'b0, 4'h0, 5'b00000},
    {lcd4_pkg::MODE_TICK,  8'h00, 1'b0, 4'h0, 5'b00000},
    {lcd4_pkg::MODE_TICK,  8'h00, 1'b1, 4'h5, 5'b01000},  // lines held after the write
    {lcd4_pkg::MODE_DATA,  8'hFF, 1'b1, 4'hF, 5'b01010},
    {lcd4_pkg::MODE_INSTR, 8'h00, 1'b1, 4'hF, 5'b11011},  // dropped as enable rises
    {lcd4_pkg::MODE_TICK,  8'hFF, 1'b0, 4'h0, 5'b00000},
    {lcd4_pkg::MODE_TICK,  8'hFF, 1'b0, 4'h0, 5'b00000},
    {lcd4_pkg::MODE_TICK,  8'hFF, 1'b0, 4'h0, 5'b00000},
    {lcd4_pkg::MODE_INIT,  8'hFF, 1'b1, 4'h0, 5'b00010},  // init pulls data and select low
    {lcd4_pkg::MODE_DATA,  8'h00, 1'b1, 4'h3, 5'b00011},  // first reset nibble goes out
    {lcd4_pkg::MODE_TICK,  8'h00, 1'b0, 4'h0, 5'b00000}
  };

  initial begin : stimulus
    int             i;
    lcd4_pkg::in_t  it;
    lcd4_pkg::cfg_t c;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    for (i = 0; i < PLAN_LEN; i++) begin
      if (i == ZERO_ROW) begin
        settle();
        set_regs('0);
      end
      send_beat(plan[i].item, plan[i].pinned, plan[i].want);
    end
    settle();

    // Random part over several timing settings.
    set_regs(CFG_DEFAULT);
    run_random(250, 1'b0);       // power-up at default timing would take far too long
    settle();

    set_regs('0);
    run_random(350, 1'b1);
    settle();

    set_regs(short_timing(3));
    run_random(350, 1'b1);
    settle();

    set_regs(short_timing(6));
    run_random(350, 1'b1);
    settle();

    // Top of range on the init gaps; byte writes only.
    c = short_timing(2);
    c.reset_gap_us   = '1;
    c.command_gap_us = '1;
    set_regs(c);
    run_random(200, 1'b0);
    settle();

    // One full power-up with longer first and last waits, no idling.
    c = '0;
    c.power_wait_us = 16'd60;
    c.clear_wait_us = 16'd45;
    set_regs(c);
    quiet <= 1'b1;
    it.mode       = lcd4_pkg::MODE_INIT;
    it.byte_value = 8'h00;
    send_beat(it, 1'b0, '0);
    settle();

    // One write with a longer setup and strobe; a second request is dropped.
    c = '0;
    c.data_setup_us   = 16'd40;
    c.enable_pulse_us = 16'd35;
    set_regs(c);
    it.mode       = lcd4_pkg::MODE_INSTR;
    it.byte_value = 8'h5A;
    send_beat(it, 1'b0, '0);
    it.mode       = lcd4_pkg::MODE_DATA;
    it.byte_value = 8'hC3;
    send_beat(it, 1'b0, '0);
    settle();

    set_regs(short_timing(4));
    run_random(150, 1'b1);
    settle();

    // Let any stray beat show up before judging.
    repeat (8) @(posedge clk);
    if (lcd_expected.size() != 0) begin
      $error("%0d expected beats never arrived", lcd_expected.size());
      errors++;
    end
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: stall out_ready for a random count after each beat and check
  // every beat against the oldest owed line levels.
  // ---------------------------------------------------------------------------
  function automatic void compare_field(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_beats
    lcd4_pkg::out_t want;
    int             hold;
    if (rst) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (lcd_expected.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
      end else begin
        want = lcd_expected.pop_front();
        compare_field("lcd_nibble", want.lcd_nibble, out_data.lcd_nibble);
        compare_field("lcd_enable", 4'(want.lcd_enable), 4'(out_data.lcd_enable));
        compare_field("lcd_register_select", 4'(want.lcd_register_select),
                      4'(out_data.lcd_register_select));
        compare_field("lcd_read_write", 4'(want.lcd_read_write),
                      4'(out_data.lcd_read_write));
        compare_field("busy_res", 4'(want.busy_res), 4'(out_data.busy_res));
        compare_field("dropped", 4'(want.dropped), 4'(out_data.dropped));
        n_out++;
      end
      // Draw the stall that follows this beat.
      hold = quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (hold != 0) begin
        out_ready  <= 1'b0;
        stall_left <= hold;
      end
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ready <= 1'b1;
    end
  end

endmodule
